FILE: rtl/gmds_pkg.sv
// Shared types, codes and the microprogram table of the grid maze solver.
package gmds_pkg;

    // Cell marks held in the grid memory
    localparam logic [1:0] MARK_OPEN = 2'd0;
    localparam logic [1:0] MARK_WALL = 2'd1;
    localparam logic [1:0] MARK_PATH = 2'd2;

    // Item kinds carried on tuser
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_SOLVE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    // Configuration register indexes
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    typedef logic [3:0] t_step;

    // Microprogram addresses
    localparam t_step S_CLEAR    = 4'd0;
    localparam t_step S_IDLE     = 4'd1;
    localparam t_step S_WRITE    = 4'd2;
    localparam t_step S_READ     = 4'd3;
    localparam t_step S_READ_OUT = 4'd4;
    localparam t_step S_NOP      = 4'd5;
    localparam t_step S_INIT     = 4'd6;
    localparam t_step S_EXAM     = 4'd7;
    localparam t_step S_STEP     = 4'd8;
    localparam t_step S_TEST     = 4'd9;
    localparam t_step S_MARK     = 4'd10;
    localparam t_step S_PUSH     = 4'd11;
    localparam t_step S_BACK     = 4'd12;
    localparam t_step S_POPW     = 4'd13;
    localparam t_step S_OK       = 4'd14;
    localparam t_step S_FAIL     = 4'd15;

    typedef enum logic [3:0] {
        C_NEXT,
        C_JUMP,
        C_DISPATCH,
        C_GOAL_START,
        C_DIR_DONE,
        C_NO_NBR,
        C_BLOCKED,
        C_AT_GOAL,
        C_LAST,
        C_CLR_MORE
    } t_cond;

    typedef enum logic [2:0] {
        G_NONE,
        G_WR_IN,
        G_RD_IN,
        G_RD_TGT,
        G_WR_PATH_START,
        G_WR_PATH_TGT,
        G_WR_OPEN_CUR,
        G_WR_OPEN_CLR
    } t_grid_op;

    typedef enum logic [2:0] {
        D_NONE,
        D_INIT,
        D_ADV,
        D_PUSH,
        D_POP,
        D_LOAD,
        D_DONE,
        D_CLR
    } t_dp_op;

    typedef enum logic [1:0] {
        R_ZERO,
        R_MARK,
        R_FOUND
    } t_res_sel;

    typedef struct packed {
        logic     in_ready;
        logic     emit;
        t_res_sel res_sel;
        t_grid_op grid_op;
        t_dp_op   dp_op;
        t_cond    cond;
        t_step    target;
    } t_ctrl;

    typedef struct packed {
        logic goal_start;
        logic dir_done;
        logic no_nbr;
        logic blocked;
        logic at_goal;
        logic last_frame;
        logic clr_more;
    } t_status;

    function automatic t_ctrl cw(input logic rdy, input logic emit, input t_res_sel res,
                                 input t_grid_op g, input t_dp_op d, input t_cond c,
                                 input t_step tgt);
        t_ctrl w;
        w.in_ready = rdy;
        w.emit     = emit;
        w.res_sel  = res;
        w.grid_op  = g;
        w.dp_op    = d;
        w.cond     = c;
        w.target   = tgt;
        return w;
    endfunction

    // Control store: one word per step
    function automatic t_ctrl rom_word(input t_step s);
        t_ctrl w;
        unique case (s)
            S_CLEAR:    w = cw(1'b0, 1'b0, R_ZERO,  G_WR_OPEN_CLR,   D_CLR,  C_CLR_MORE,   S_CLEAR);
            S_IDLE:     w = cw(1'b1, 1'b0, R_ZERO,  G_NONE,          D_NONE, C_DISPATCH,   S_IDLE);
            S_WRITE:    w = cw(1'b0, 1'b1, R_ZERO,  G_WR_IN,         D_NONE, C_JUMP,       S_IDLE);
            S_READ:     w = cw(1'b0, 1'b0, R_ZERO,  G_RD_IN,         D_NONE, C_NEXT,       S_IDLE);
            S_READ_OUT: w = cw(1'b0, 1'b1, R_MARK,  G_NONE,          D_NONE, C_JUMP,       S_IDLE);
            S_NOP:      w = cw(1'b0, 1'b1, R_ZERO,  G_NONE,          D_NONE, C_JUMP,       S_IDLE);
            S_INIT:     w = cw(1'b0, 1'b0, R_ZERO,  G_WR_PATH_START, D_INIT, C_GOAL_START, S_OK);
            S_EXAM:     w = cw(1'b0, 1'b0, R_ZERO,  G_NONE,          D_NONE, C_DIR_DONE,   S_BACK);
            S_STEP:     w = cw(1'b0, 1'b0, R_ZERO,  G_RD_TGT,        D_ADV,  C_NO_NBR,     S_EXAM);
            S_TEST:     w = cw(1'b0, 1'b0, R_ZERO,  G_NONE,          D_NONE, C_BLOCKED,    S_EXAM);
            S_MARK:     w = cw(1'b0, 1'b0, R_ZERO,  G_WR_PATH_TGT,   D_NONE, C_AT_GOAL,    S_OK);
            S_PUSH:     w = cw(1'b0, 1'b0, R_ZERO,  G_NONE,          D_PUSH, C_JUMP,       S_EXAM);
            S_BACK:     w = cw(1'b0, 1'b0, R_ZERO,  G_WR_OPEN_CUR,   D_POP,  C_LAST,       S_FAIL);
            S_POPW:     w = cw(1'b0, 1'b0, R_ZERO,  G_NONE,          D_LOAD, C_JUMP,       S_EXAM);
            S_OK:       w = cw(1'b0, 1'b1, R_FOUND, G_NONE,          D_DONE, C_JUMP,       S_IDLE);
            S_FAIL:     w = cw(1'b0, 1'b1, R_ZERO,  G_NONE,          D_DONE, C_JUMP,       S_IDLE);
            default:    w = cw(1'b0, 1'b0, R_ZERO,  G_NONE,          D_NONE, C_JUMP,       S_IDLE);
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/gmds_cell_mem.sv
// Grid cell memory: one write port, one read port with registered data.
module gmds_cell_mem #(
    parameter int AW = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [1:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [1:0]    o_rdata
);

    logic [1:0] mem [0:(1 << AW) - 1];
    logic [1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/gmds_sequencer.sv
// Microprogram sequencer: step counter, control store and jump logic.
module gmds_sequencer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_kind,
    input  logic              i_out_free,
    input  gmds_pkg::t_status i_status,
    output gmds_pkg::t_ctrl   o_ctrl,
    output logic              o_fire
);

    gmds_pkg::t_step r_step;
    gmds_pkg::t_step n_step;
    gmds_pkg::t_step step_inc;
    gmds_pkg::t_step dispatch;
    gmds_pkg::t_ctrl ctrl;
    logic            hold;
    logic            flag;

    assign ctrl     = gmds_pkg::rom_word(r_step);
    assign step_inc = r_step + 4'd1;

    // Stall on an empty input in the idle step, or on a full result slot
    assign hold   = (ctrl.in_ready && !i_in_valid) || (ctrl.emit && !i_out_free);
    assign o_fire = !hold;
    assign o_ctrl = ctrl;

    always_comb begin
        unique case (i_kind)
            gmds_pkg::KIND_WRITE: dispatch = gmds_pkg::S_WRITE;
            gmds_pkg::KIND_SOLVE: dispatch = gmds_pkg::S_INIT;
            gmds_pkg::KIND_READ:  dispatch = gmds_pkg::S_READ;
            gmds_pkg::KIND_NONE:  dispatch = gmds_pkg::S_NOP;
            default:              dispatch = gmds_pkg::S_NOP;
        endcase
    end

    always_comb begin
        unique case (ctrl.cond)
            gmds_pkg::C_GOAL_START: flag = i_status.goal_start;
            gmds_pkg::C_DIR_DONE:   flag = i_status.dir_done;
            gmds_pkg::C_NO_NBR:     flag = i_status.no_nbr;
            gmds_pkg::C_BLOCKED:    flag = i_status.blocked;
            gmds_pkg::C_AT_GOAL:    flag = i_status.at_goal;
            gmds_pkg::C_LAST:       flag = i_status.last_frame;
            gmds_pkg::C_CLR_MORE:   flag = i_status.clr_more;
            default:                flag = 1'b0;
        endcase
    end

    always_comb begin
        unique case (ctrl.cond)
            gmds_pkg::C_NEXT:     n_step = step_inc;
            gmds_pkg::C_JUMP:     n_step = ctrl.target;
            gmds_pkg::C_DISPATCH: n_step = dispatch;
            default:              n_step = flag ? ctrl.target : step_inc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= gmds_pkg::S_CLEAR;
        end else if (!hold) begin
            r_step <= n_step;
        end
    end

endmodule

FILE: rtl/gmds_datapath.sv
// Search datapath: item latch, route registers, frame stack and grid access.
module gmds_datapath #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 32,
    localparam int RW = $clog2(MAX_ROWS),
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  gmds_pkg::t_ctrl       i_ctrl,
    input  logic                  i_fire,
    input  logic [4:0]            i_row,
    input  logic [4:0]            i_col,
    input  logic                  i_wall,
    input  logic [5:0]            i_rows_cfg,
    input  logic [5:0]            i_cols_cfg,
    output logic                  o_grid_we,
    output logic [RW+CW-1:0]      o_grid_waddr,
    output logic [1:0]            o_grid_wdata,
    output logic                  o_grid_re,
    output logic [RW+CW-1:0]      o_grid_raddr,
    input  logic [1:0]            i_grid_rdata,
    output gmds_pkg::t_status     o_status,
    output logic                  o_found,
    output logic [1:0]            o_mark
);

    localparam int AW = RW + CW;
    localparam int FW = AW + 3;
    localparam logic [8:0] MaxR = 9'(MAX_ROWS);
    localparam logic [8:0] MaxC = 9'(MAX_COLS);
    localparam logic [AW-1:0] StartAddr = {RW'(1), CW'(0)};

    logic [4:0]    r_in_row;
    logic [4:0]    r_in_col;
    logic          r_in_wall;
    logic [AW-1:0] r_cur;
    logic [2:0]    r_dir;
    logic [AW-1:0] r_tgt;
    logic [AW:0]   r_sp;
    logic [AW-1:0] r_clr;
    logic [FW-1:0] r_stk_rd;
    logic [FW-1:0] stack [0:(1 << AW) - 1];

    logic [8:0]    rows9;
    logic [8:0]    cols9;
    logic [8:0]    nr;
    logic [8:0]    nc;
    logic [8:0]    goal_r;
    logic [8:0]    goal_c;
    logic [8:0]    in_row9;
    logic [8:0]    in_col9;
    logic          in_inside;
    logic [AW-1:0] in_addr;
    logic [RW-1:0] cur_row;
    logic [CW-1:0] cur_col;
    logic [RW-1:0] nb_row;
    logic [CW-1:0] nb_col;
    logic          nb_ok;
    logic [AW-1:0] nb_addr;
    logic [AW:0]   sp_m1;
    logic [AW:0]   sp_m2;
    logic          upd;

    assign upd = i_fire;

    // Clamp the configured grid size to what a solve may use
    assign rows9  = 9'(i_rows_cfg);
    assign cols9  = 9'(i_cols_cfg);
    assign nr     = (rows9 < 9'd2) ? 9'd2 : ((rows9 > MaxR) ? MaxR : rows9);
    assign nc     = (cols9 < 9'd1) ? 9'd1 : ((cols9 > MaxC) ? MaxC : cols9);
    assign goal_r = nr - 9'd2;
    assign goal_c = nc - 9'd1;

    assign in_row9   = 9'(r_in_row);
    assign in_col9   = 9'(r_in_col);
    assign in_inside = (in_row9 < MaxR) && (in_col9 < MaxC);
    assign in_addr   = {in_row9[RW-1:0], in_col9[CW-1:0]};

    assign cur_row = r_cur[AW-1:CW];
    assign cur_col = r_cur[CW-1:0];

    // Neighbour in the order down, up, right, left
    always_comb begin
        nb_row = cur_row;
        nb_col = cur_col;
        unique case (r_dir[1:0])
            2'd0: begin
                nb_ok  = (9'(cur_row) + 9'd1) < nr;
                nb_row = cur_row + RW'(1);
            end
            2'd1: begin
                nb_ok  = (cur_row != '0);
                nb_row = cur_row - RW'(1);
            end
            2'd2: begin
                nb_ok  = (9'(cur_col) + 9'd1) < nc;
                nb_col = cur_col + CW'(1);
            end
            default: begin
                nb_ok  = (cur_col != '0);
                nb_col = cur_col - CW'(1);
            end
        endcase
    end
    assign nb_addr = {nb_row, nb_col};

    assign sp_m1 = r_sp - (AW + 1)'(1);
    assign sp_m2 = r_sp - (AW + 1)'(2);

    // Grid port selection
    always_comb begin
        o_grid_we    = 1'b0;
        o_grid_waddr = r_cur;
        o_grid_wdata = gmds_pkg::MARK_OPEN;
        unique case (i_ctrl.grid_op)
            gmds_pkg::G_WR_IN: begin
                o_grid_we    = upd && in_inside;
                o_grid_waddr = in_addr;
                o_grid_wdata = r_in_wall ? gmds_pkg::MARK_WALL : gmds_pkg::MARK_OPEN;
            end
            gmds_pkg::G_WR_PATH_START: begin
                o_grid_we    = upd;
                o_grid_waddr = StartAddr;
                o_grid_wdata = gmds_pkg::MARK_PATH;
            end
            gmds_pkg::G_WR_PATH_TGT: begin
                o_grid_we    = upd;
                o_grid_waddr = r_tgt;
                o_grid_wdata = gmds_pkg::MARK_PATH;
            end
            gmds_pkg::G_WR_OPEN_CUR: begin
                o_grid_we    = upd;
                o_grid_waddr = r_cur;
            end
            gmds_pkg::G_WR_OPEN_CLR: begin
                o_grid_we    = upd;
                o_grid_waddr = r_clr;
            end
            default: begin
                o_grid_we = 1'b0;
            end
        endcase
    end

    assign o_grid_re    = (i_ctrl.grid_op == gmds_pkg::G_RD_IN) ||
                          (i_ctrl.grid_op == gmds_pkg::G_RD_TGT);
    assign o_grid_raddr = (i_ctrl.grid_op == gmds_pkg::G_RD_TGT) ? nb_addr : in_addr;

    // Latch the item fields on acceptance
    always_ff @(posedge i_clk) begin
        if (upd && i_ctrl.in_ready) begin
            r_in_row  <= i_row;
            r_in_col  <= i_col;
            r_in_wall <= i_wall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp  <= '0;
            r_clr <= '0;
        end else if (upd) begin
            unique case (i_ctrl.dp_op)
                gmds_pkg::D_INIT: r_sp  <= (AW + 1)'(1);
                gmds_pkg::D_PUSH: r_sp  <= r_sp + (AW + 1)'(1);
                gmds_pkg::D_POP:  r_sp  <= sp_m1;
                gmds_pkg::D_DONE: r_sp  <= '0;
                gmds_pkg::D_CLR:  r_clr <= r_clr + AW'(1);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd) begin
            unique case (i_ctrl.dp_op)
                gmds_pkg::D_INIT: begin
                    r_cur <= StartAddr;
                    r_dir <= 3'd0;
                end
                gmds_pkg::D_ADV: begin
                    r_tgt <= nb_addr;
                    r_dir <= r_dir + 3'd1;
                end
                gmds_pkg::D_PUSH: begin
                    r_cur <= r_tgt;
                    r_dir <= 3'd0;
                end
                gmds_pkg::D_LOAD: begin
                    r_cur <= r_stk_rd[FW-1:3];
                    r_dir <= r_stk_rd[2:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Frame stack: the top frame lives in r_cur/r_dir, the rest in memory
    always_ff @(posedge i_clk) begin
        if (upd && (i_ctrl.dp_op == gmds_pkg::D_PUSH)) begin
            stack[sp_m1[AW-1:0]] <= {r_cur, r_dir};
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd && (i_ctrl.dp_op == gmds_pkg::D_POP)) begin
            r_stk_rd <= stack[sp_m2[AW-1:0]];
        end
    end

    assign o_status.goal_start = (goal_r == 9'd1) && (goal_c == 9'd0);
    assign o_status.dir_done   = r_dir[2];
    assign o_status.no_nbr     = !nb_ok;
    assign o_status.blocked    = (i_grid_rdata != gmds_pkg::MARK_OPEN);
    assign o_status.at_goal    = (9'(r_tgt[AW-1:CW]) == goal_r) &&
                                 (9'(r_tgt[CW-1:0]) == goal_c);
    assign o_status.last_frame = (r_sp == (AW + 1)'(1));
    assign o_status.clr_more   = (r_clr != '1);

    assign o_found = (i_ctrl.res_sel == gmds_pkg::R_FOUND);
    assign o_mark  = ((i_ctrl.res_sel == gmds_pkg::R_MARK) && in_inside) ?
                     i_grid_rdata : gmds_pkg::MARK_OPEN;

endmodule

FILE: rtl/grid_maze_dfs_solver_unit.sv
// Grid maze solver top level: stream ports, configuration and result register.
//
// Holds a MAX_ROWS x MAX_COLS grid of cells (open, wall or path) and answers one
// result per input transaction. tuser selects the kind: write a cell, read a
// cell, or solve. A solve runs a depth-first backtracking search from row 1,
// column 0 to row rows_in_use-2, column cols_in_use-1, trying down, up, right,
// left; on success the route stays marked path and found is 1, on failure all
// cells it touched are open again. Control is a microprogram of sixteen steps
// driving one grid memory port pair and a frame stack memory. The length of a
// solve follows the maze and may grow exponentially with it. After reset the
// block sweeps all 2^AW cells of the grid (1024 by default) to open, one cell
// a cycle, before tready first rises; configuration writes are taken
// throughout. The result sits in an output register, so the next transaction
// is taken while the last result waits; the step that produces the following
// result holds until that register has been drained.
module grid_maze_dfs_solver_unit #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // [4:0] row_index, [9:5] col_index, [10] is_wall
    input  logic [1:0]  i_s_axis_tuser,  // [1:0] kind
    // Result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,  // [0] found, [2:1] mark
    // Configuration writes
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [5:0]  i_cfg_data
);

    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int AW = RW + CW;

    gmds_pkg::t_ctrl   ctrl;
    gmds_pkg::t_status status;
    logic              fire;
    logic              out_free;
    logic              res_found;
    logic [1:0]        res_mark;

    logic              grid_we;
    logic [AW-1:0]     grid_waddr;
    logic [1:0]        grid_wdata;
    logic              grid_re;
    logic [AW-1:0]     grid_raddr;
    logic [1:0]        grid_rdata;

    logic [5:0]        r_rows;
    logic [5:0]        r_cols;
    logic              r_out_valid;
    logic              r_out_found;
    logic [1:0]        r_out_mark;

    // Configuration registers; index beyond the list does not exist on a 1-bit port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= 6'd32;
            r_cols <= 6'd32;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                gmds_pkg::CFG_ROWS: r_rows <= i_cfg_data;
                gmds_pkg::CFG_COLS: r_cols <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Result slot is free when empty or being drained this cycle
    assign out_free = !r_out_valid || i_m_axis_tready;

    gmds_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_kind     (i_s_axis_tuser),
        .i_out_free (out_free),
        .i_status   (status),
        .o_ctrl     (ctrl),
        .o_fire     (fire)
    );

    gmds_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .i_fire       (fire),
        .i_row        (i_s_axis_tdata[4:0]),
        .i_col        (i_s_axis_tdata[9:5]),
        .i_wall       (i_s_axis_tdata[10]),
        .i_rows_cfg   (r_rows),
        .i_cols_cfg   (r_cols),
        .o_grid_we    (grid_we),
        .o_grid_waddr (grid_waddr),
        .o_grid_wdata (grid_wdata),
        .o_grid_re    (grid_re),
        .o_grid_raddr (grid_raddr),
        .i_grid_rdata (grid_rdata),
        .o_status     (status),
        .o_found      (res_found),
        .o_mark       (res_mark)
    );

    gmds_cell_mem #(
        .AW (AW)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (grid_we),
        .i_waddr (grid_waddr),
        .i_wdata (grid_wdata),
        .i_re    (grid_re),
        .i_raddr (grid_raddr),
        .o_rdata (grid_rdata)
    );

    // Result register: load on an emitting step, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && ctrl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && ctrl.emit) begin
            r_out_found <= res_found;
            r_out_mark  <= res_mark;
        end
    end

    assign o_s_axis_tready = ctrl.in_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out_mark, r_out_found};

endmodule

FILE: verif/grid_maze_dfs_solver_unit_test.sv
// Self-checking testbench for the grid maze solver: directed cases, then random mazes.
module grid_maze_dfs_solver_unit_test;

    localparam int GRID_ROWS  = 32;
    localparam int GRID_COLS  = 32;
    localparam int GRID_CELLS = GRID_ROWS * GRID_COLS;

    // Cap on search iterations per solve; a solve that would run longer is
    // replaced by a read of the same cell so the run stays bounded.
    localparam int STEP_BUDGET  = 4000;
    localparam int ITEM_TARGET  = 1300;
    localparam int LIMIT_CYCLES = 30000000;
    localparam int REPORT_LIMIT = 10;

    // Search outcomes
    localparam int SEARCH_OVER    = -1;
    localparam int SEARCH_FAILED  = 0;
    localparam int SEARCH_FOUND   = 1;
    localparam int SEARCH_RUNNING = 2;

    // Neighbour order tried from each cell
    localparam int DIR_DOWN  = 0;
    localparam int DIR_UP    = 1;
    localparam int DIR_RIGHT = 2;
    localparam int DIR_LEFT  = 3;
    localparam int DIR_DONE  = 4;

    typedef struct packed {
        logic       found;
        logic [1:0] mark;
    } t_maze_answer;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata  = '0;     // [4:0] row_index, [9:5] col_index, [10] is_wall
    logic [1:0]  i_s_axis_tuser  = gmds_pkg::KIND_NONE; // [1:0] kind
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [7:0]  o_m_axis_tdata;           // [0] found, [2:1] mark
    logic        i_cfg_we        = 1'b0;
    logic        i_cfg_index     = gmds_pkg::CFG_ROWS;
    logic [5:0]  i_cfg_data      = '0;

    // Predicted block state
    logic [1:0]   maze_cells  [GRID_CELLS];
    logic [1:0]   trial_cells [GRID_CELLS];
    int           route_cell  [GRID_CELLS];
    int           route_dir   [GRID_CELLS];
    logic [5:0]   rows_cfg = 6'd32;
    logic [5:0]   cols_cfg = 6'd32;

    t_maze_answer pending_answers[$];
    int           items_sent   = 0;
    int           results_seen = 0;
    int           fail_count   = 0;
    int           cycle_count  = 0;
    bit           send_burst   = 1'b0;
    bit           take_burst   = 1'b0;

    grid_maze_dfs_solver_unit #(
        .MAX_ROWS(GRID_ROWS),
        .MAX_COLS(GRID_COLS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop: a hung handshake or a runaway search ends here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("grid_maze_dfs_solver_unit_test failed");
            $finish;
        end
    end

    // Depth-first walk on a scratch copy of the grid. The copy is committed only
    // when the walk ends within the budget, so an abandoned solve leaves the
    // predicted grid untouched.
    function automatic int walk_maze();
        int nr, nc, goal_r, goal_c, depth, steps, cur, d, r, c, tr, tc, nxt, outcome;
        bit ok;
        nr = (rows_cfg < 2) ? 2 : ((rows_cfg > GRID_ROWS) ? GRID_ROWS : int'(rows_cfg));
        nc = (cols_cfg < 1) ? 1 : ((cols_cfg > GRID_COLS) ? GRID_COLS : int'(cols_cfg));
        goal_r  = nr - 2;
        goal_c  = nc - 1;
        depth   = 0;
        steps   = 0;
        outcome = SEARCH_RUNNING;
        for (int i = 0; i < GRID_CELLS; i++) trial_cells[i] = maze_cells[i];

        // The start cell is forced to path, wall or not
        trial_cells[GRID_COLS] = gmds_pkg::MARK_PATH;
        if (goal_r == 1 && goal_c == 0) begin
            outcome = SEARCH_FOUND;
        end else begin
            route_cell[0] = GRID_COLS;
            route_dir[0]  = DIR_DOWN;
            depth         = 1;
        end

        while (depth > 0 && outcome == SEARCH_RUNNING) begin
            if (steps == STEP_BUDGET) begin
                outcome = SEARCH_OVER;
            end else begin
                steps++;
                cur = route_cell[depth-1];
                d   = route_dir[depth-1];
                if (d >= DIR_DONE) begin
                    // Dead end: reopen the cell and drop the frame
                    trial_cells[cur] = gmds_pkg::MARK_OPEN;
                    depth--;
                end else begin
                    route_dir[depth-1] = d + 1;
                    r  = cur / GRID_COLS;
                    c  = cur % GRID_COLS;
                    tr = r;
                    tc = c;
                    ok = 1'b0;
                    case (d)
                        DIR_DOWN:  if (r + 1 < nr) begin tr = r + 1; ok = 1'b1; end
                        DIR_UP:    if (r > 0)      begin tr = r - 1; ok = 1'b1; end
                        DIR_RIGHT: if (c + 1 < nc) begin tc = c + 1; ok = 1'b1; end
                        default:   if (c > 0)      begin tc = c - 1; ok = 1'b1; end
                    endcase
                    if (ok) begin
                        nxt = tr * GRID_COLS + tc;
                        // Walls and earlier path marks both block the way
                        if (trial_cells[nxt] == gmds_pkg::MARK_OPEN) begin
                            trial_cells[nxt] = gmds_pkg::MARK_PATH;
                            if (tr == goal_r && tc == goal_c) begin
                                outcome = SEARCH_FOUND;
                            end else begin
                                route_cell[depth] = nxt;
                                route_dir[depth]  = DIR_DOWN;
                                depth++;
                            end
                        end
                    end
                end
            end
        end

        if (outcome == SEARCH_RUNNING) outcome = SEARCH_FAILED;
        if (outcome != SEARCH_OVER) begin
            for (int i = 0; i < GRID_CELLS; i++) maze_cells[i] = trial_cells[i];
        end
        return outcome;
    endfunction

    // Predict, present and hand over one item; queue its answer once accepted.
    task automatic send_item(input logic [1:0] kind, input logic [4:0] row,
                             input logic [4:0] col, input logic wall);
        t_maze_answer answer;
        logic [1:0]   sent_kind;
        int           outcome;
        int           gap;
        answer    = '0;
        sent_kind = kind;
        case (kind)
            gmds_pkg::KIND_WRITE:
                maze_cells[row * GRID_COLS + col] =
                    wall ? gmds_pkg::MARK_WALL : gmds_pkg::MARK_OPEN;
            gmds_pkg::KIND_SOLVE: begin
                outcome = walk_maze();
                if (outcome == SEARCH_OVER) begin
                    // Too long to simulate: read the same cell instead
                    sent_kind   = gmds_pkg::KIND_READ;
                    answer.mark = maze_cells[row * GRID_COLS + col];
                end else begin
                    answer.found = (outcome == SEARCH_FOUND);
                end
            end
            gmds_pkg::KIND_READ:  answer.mark = maze_cells[row * GRID_COLS + col];
            default:    ;
        endcase

        gap = send_burst ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {5'b0, wall, col, row};
        i_s_axis_tuser  <= sent_kind;
        do @(posedge i_clk); while (!(i_s_axis_tvalid && o_s_axis_tready));
        pending_answers.insert(pending_answers.size(), answer);
        items_sent++;
    endtask

    // Hold the input side quiet until every queued answer has come back.
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
    endtask

    // Write both size registers while the block is idle.
    task automatic set_limits(input logic [5:0] rows, input logic [5:0] cols);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= gmds_pkg::CFG_ROWS;
        i_cfg_data  <= rows;
        @(posedge i_clk);
        i_cfg_index <= gmds_pkg::CFG_COLS;
        i_cfg_data  <= cols;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        rows_cfg = rows;
        cols_cfg = cols;
    endtask

    // Result side: stall for a drawn number of cycles before each transaction.
    initial begin : result_sink
        int stall;
        @(posedge i_clk);
        forever begin
            stall = take_burst ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_axis_tvalid && i_m_axis_tready));
        end
    end

    // Compare every result transaction with the oldest queued answer.
    always @(posedge i_clk) begin
        t_maze_answer want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            if (pending_answers.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("result %0d arrived with no answer queued: found=%0d mark=%0d",
                             results_seen, o_m_axis_tdata[0], o_m_axis_tdata[2:1]);
            end else begin
                want = pending_answers.pop_front();
                if (o_m_axis_tdata[0] !== want.found || o_m_axis_tdata[2:1] !== want.mark) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("result %0d: expected found=%0d mark=%0d, got found=%0d mark=%0d",
                                 results_seen, want.found, want.mark,
                                 o_m_axis_tdata[0], o_m_axis_tdata[2:1]);
                end
            end
        end
    end

    // Grid must come out of reset all open; an unknown kind answers all zero.
    task automatic test_reset_state();
        send_item(gmds_pkg::KIND_READ, 5'd0, 5'd0, 1'b0);
        send_item(gmds_pkg::KIND_READ, 5'd31, 5'd31, 1'b1);
        send_item(gmds_pkg::KIND_READ, 5'd1, 5'd0, 1'b0);
        send_item(gmds_pkg::KIND_NONE, 5'd31, 5'd31, 1'b1);
    endtask

    // Corner cells with all-zero and all-one indexes, written and read back.
    task automatic test_cell_access();
        send_item(gmds_pkg::KIND_WRITE, 5'd31, 5'd31, 1'b1);
        send_item(gmds_pkg::KIND_READ, 5'd31, 5'd31, 1'b0);
        send_item(gmds_pkg::KIND_WRITE, 5'd0, 5'd0, 1'b1);
        send_item(gmds_pkg::KIND_READ, 5'd0, 5'd0, 1'b0);
        send_item(gmds_pkg::KIND_WRITE, 5'd31, 5'd31, 1'b0);
        send_item(gmds_pkg::KIND_READ, 5'd31, 5'd31, 1'b1);
    endtask

    // Register extremes, a failing search, a walled start, start on the exit
    // and a full-size grid partly blocked by an earlier route.
    task automatic test_register_extremes();
        // Both registers below range: a 2 x 1 grid whose exit is the walled corner
        set_limits(6'd0, 6'd0);
        send_item(gmds_pkg::KIND_SOLVE, 5'd0, 5'd0, 1'b0);
        send_item(gmds_pkg::KIND_READ, 5'd1, 5'd0, 1'b0);
        // Wall the start and open the exit: the start is taken anyway
        send_item(gmds_pkg::KIND_WRITE, 5'd1, 5'd0, 1'b1);
        send_item(gmds_pkg::KIND_WRITE, 5'd0, 5'd0, 1'b0);
        send_item(gmds_pkg::KIND_SOLVE, 5'd0, 5'd0, 1'b0);
        send_item(gmds_pkg::KIND_READ, 5'd0, 5'd0, 1'b0);
        send_item(gmds_pkg::KIND_READ, 5'd1, 5'd0, 1'b0);
        // Three rows, one column: the exit is the start itself
        set_limits(6'd3, 6'd1);
        send_item(gmds_pkg::KIND_SOLVE, 5'd1, 5'd0, 1'b0);
        // Both registers above range: full grid
        set_limits(6'd63, 6'd40);
        send_item(gmds_pkg::KIND_SOLVE, 5'd30, 5'd31, 1'b0);
        send_item(gmds_pkg::KIND_READ, 5'd30, 5'd31, 1'b0);
    endtask

    // One well-formed maze: size it, lay walls, solve, inspect, then some noise.
    task automatic run_maze_phase();
        int         rv, cv, nr, nc, density;
        logic [4:0] gr, gc;
        rv = $urandom_range(2, 8);
        cv = $urandom_range(1, 8);
        if ($urandom_range(0, 7) == 0) rv = $urandom_range(0, 63);
        if ($urandom_range(0, 7) == 0) cv = $urandom_range(0, 63);
        set_limits(rv[5:0], cv[5:0]);
        nr = (rv < 2) ? 2 : ((rv > GRID_ROWS) ? GRID_ROWS : rv);
        nc = (cv < 1) ? 1 : ((cv > GRID_COLS) ? GRID_COLS : cv);
        gr = 5'(nr - 2);
        gc = 5'(nc - 1);
        density    = $urandom_range(15, 50);
        send_burst = ($urandom_range(0, 3) == 0);
        take_burst = ($urandom_range(0, 3) == 0);

        if (nr * nc <= 64) begin
            // Skip the odd cell so stale route marks sometimes survive
            for (int r = 0; r < nr; r++)
                for (int c = 0; c < nc; c++)
                    if ($urandom_range(0, 9) != 0)
                        send_item(gmds_pkg::KIND_WRITE, r[4:0], c[4:0],
                                  $urandom_range(0, 99) < density);
        end else begin
            repeat (24)
                send_item(gmds_pkg::KIND_WRITE, 5'($urandom_range(0, nr - 1)),
                          5'($urandom_range(0, nc - 1)),
                          $urandom_range(0, 99) < density);
        end
        if ($urandom_range(0, 1) == 0) begin
            send_item(gmds_pkg::KIND_WRITE, 5'd1, 5'd0, 1'b0);
            send_item(gmds_pkg::KIND_WRITE, gr, gc, 1'b0);
        end

        send_item(gmds_pkg::KIND_SOLVE, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                  1'($urandom_range(0, 1)));
        send_item(gmds_pkg::KIND_READ, gr, gc, 1'($urandom_range(0, 1)));
        send_item(gmds_pkg::KIND_READ, 5'd1, 5'd0, 1'($urandom_range(0, 1)));
        repeat (4)
            send_item(gmds_pkg::KIND_READ, 5'($urandom_range(0, nr - 1)),
                      5'($urandom_range(0, nc - 1)), 1'($urandom_range(0, 1)));
        // Now and then a second solve runs into any route left by the first
        if ($urandom_range(0, 2) == 0) begin
            send_item(gmds_pkg::KIND_SOLVE, 5'($urandom_range(0, 31)),
                      5'($urandom_range(0, 31)), 1'b0);
            send_item(gmds_pkg::KIND_READ, gr, gc, 1'b1);
        end

        repeat ($urandom_range(0, 3))
            send_item(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                      5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
    endtask

    task automatic test_random_mazes();
        while (items_sent < ITEM_TARGET) run_maze_phase();
    endtask

    initial begin
        for (int i = 0; i < GRID_CELLS; i++) maze_cells[i] = gmds_pkg::MARK_OPEN;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_cell_access();
        test_register_extremes();
        test_random_mazes();

        // Let the last results drain, then watch a little longer for strays
        wait_drained();
        repeat (40) @(posedge i_clk);
        if (pending_answers.size() != 0) begin
            fail_count++;
            $display("%0d answers still outstanding at the end", pending_answers.size());
        end

        if (fail_count == 0)
            $display("grid_maze_dfs_solver_unit_test passed");
        else
            $display("grid_maze_dfs_solver_unit_test failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/gmds_pkg.sv
rtl/gmds_cell_mem.sv
rtl/gmds_sequencer.sv
rtl/gmds_datapath.sv
rtl/grid_maze_dfs_solver_unit.sv
verif/grid_maze_dfs_solver_unit_test.sv
